// File: sv/batch_min_max_mean_variance_assert.svh
// Assertion macros shared by the batch statistics RTL.
`ifndef BATCH_MIN_MAX_MEAN_VARIANCE_ASSERT_SVH
`define BATCH_MIN_MAX_MEAN_VARIANCE_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define BMMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define BMMV_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// File: sv/bmmv_pkg.sv
// Package of widths, constants and link types for the batch statistics block.
package bmmv_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAX_BATCH   = 1024;
    localparam int CNT_W       = $clog2(MAX_BATCH + 1);
    localparam int SUM_W       = SAMPLE_W + $clog2(MAX_BATCH);
    localparam int SQ_W        = 2 * SAMPLE_W + $clog2(MAX_BATCH);
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int MEAN_W      = 16;
    localparam int MSQ_W       = 32;
    localparam int DIV_W       = SQ_W;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int RESET_BATCH = 1000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: sv/bmmv_mul.sv
// Shared registered multiplier for sample squares and the squared mean.
module bmmv_mul
    import bmmv_pkg::*;
(
    input  logic                aclk,
    input  logic [SAMPLE_W-1:0] a,
    input  logic [SAMPLE_W-1:0] b,
    output logic [PROD_W-1:0]   prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// File: sv/bmmv_div.sv
// Restoring divider, one quotient bit per cycle, shared by both means.
module bmmv_div
    import bmmv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     divisor_reg;
    logic [DIV_W-1:0]     quot_reg;

    logic [CNT_W:0]       trial;
    logic                 fits;
    logic [CNT_W-1:0]     rem_next;
    logic [DIV_W-1:0]     quot_next;

    always_comb begin
        trial     = {rem_reg, quot_reg[DIV_W-1]};
        fits      = trial >= {1'b0, divisor_reg};
        rem_next  = fits ? CNT_W'(trial - {1'b0, divisor_reg}) : trial[CNT_W-1:0];
        quot_next = {quot_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (req.start && !busy_reg) begin
                busy_reg    <= 1'b1;
                cnt_reg     <= DIV_CNT_W'(DIV_W);
                rem_reg     <= '0;
                quot_reg    <= req.dividend;
                divisor_reg <= req.divisor;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quot_reg <= quot_next;
                cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// File: sv/batch_min_max_mean_variance.sv
// Top level: batch min, max, mean, mean of squares and variance over unsigned samples.
//
//  channel  | handshake          | words
//  ---------+--------------------+-------------------------------------------------
//  input    | s_valid / s_ready  | s_sample
//  result   | m_valid / m_ready  | m_max_value m_min_value m_mean_value
//           |                    | m_mean_square m_variance
//  config   | cfg_valid/cfg_ready| cfg_batch_size
//
//  A sample passes through accept, square in the shared multiplier and accumulate;
//  no new sample is taken until it is done. The last sample of a batch adds two
//  passes of the bit-serial divider plus hand-off, squared mean and output load.
//  The result sits in an output register; the next batch starts while it waits,
//  and only a further finished batch stalls until that register is taken.
//  Synchronous active-low reset; batch size resets to 1000.
module batch_min_max_mean_variance
    import bmmv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_W-1:0]    cfg_batch_size,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_max_value,
    output logic [15:0]         m_min_value,
    output logic [MEAN_W-1:0]   m_mean_value,
    output logic [MSQ_W-1:0]    m_mean_square,
    output logic [MSQ_W-1:0]    m_variance
);

    `include "batch_min_max_mean_variance_assert.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV_SUM,
        ST_WAIT_SUM,
        ST_DIV_SQ,
        ST_WAIT_SQ,
        ST_MEAN_SQ,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    batch_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]     sumsq_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic [MSQ_W-1:0]    msq_reg;
    logic                m_valid_reg;
    logic [15:0]         m_max_reg;
    logic [15:0]         m_min_reg;
    logic [MEAN_W-1:0]   m_mean_reg;
    logic [MSQ_W-1:0]    m_msq_reg;
    logic [MSQ_W-1:0]    m_var_reg;

    logic [CNT_W-1:0]    eff_size;
    logic                in_accept;
    logic                out_load;
    logic [SAMPLE_W-1:0] mul_a;
    logic [PROD_W-1:0]   prod;
    logic [MSQ_W-1:0]    var_value;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    always_comb begin
        if (batch_reg == '0) begin
            eff_size = CNT_W'(1);
        end else if (batch_reg > CNT_W'(MAX_BATCH)) begin
            eff_size = CNT_W'(MAX_BATCH);
        end else begin
            eff_size = batch_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // square the sample while accumulating, the mean after division
    assign mul_a = (state_reg == ST_SQUARE) ? sample_reg : SAMPLE_W'(mean_reg);

    bmmv_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_a),
        .prod (prod)
    );

    always_comb begin
        div_req.start    = (state_reg == ST_DIV_SUM) || (state_reg == ST_DIV_SQ);
        div_req.dividend = (state_reg == ST_DIV_SQ) ? sumsq_reg : DIV_W'(sum_reg);
        div_req.divisor  = count_reg;
    end

    bmmv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign var_value = (msq_reg >= MSQ_W'(prod)) ? (msq_reg - MSQ_W'(prod)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            batch_reg   <= CNT_W'(RESET_BATCH);
            count_reg   <= '0;
            max_reg     <= '0;
            min_reg     <= '1;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                batch_reg <= cfg_batch_size;
            end
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        sample_reg <= s_sample;
                        count_reg  <= count_reg + CNT_W'(1);
                        if (s_sample > max_reg) begin
                            max_reg <= s_sample;
                        end
                        if (s_sample < min_reg) begin
                            min_reg <= s_sample;
                        end
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    sum_reg   <= sum_reg + SUM_W'(sample_reg);
                    sumsq_reg <= sumsq_reg + SQ_W'(prod);
                    state_reg <= (count_reg >= eff_size) ? ST_DIV_SUM : ST_IDLE;
                end
                ST_DIV_SUM: begin
                    state_reg <= ST_WAIT_SUM;
                end
                ST_WAIT_SUM: begin
                    if (div_rsp.done) begin
                        mean_reg  <= div_rsp.quotient[MEAN_W-1:0];
                        state_reg <= ST_DIV_SQ;
                    end
                end
                ST_DIV_SQ: begin
                    state_reg <= ST_WAIT_SQ;
                end
                ST_WAIT_SQ: begin
                    if (div_rsp.done) begin
                        msq_reg   <= div_rsp.quotient[MSQ_W-1:0];
                        state_reg <= ST_MEAN_SQ;
                    end
                end
                ST_MEAN_SQ: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_valid_reg <= 1'b1;
                        m_max_reg   <= 16'(max_reg);
                        m_min_reg   <= 16'(min_reg);
                        m_mean_reg  <= mean_reg;
                        m_msq_reg   <= msq_reg;
                        m_var_reg   <= var_value;
                        count_reg   <= '0;
                        max_reg     <= '0;
                        min_reg     <= '1;
                        sum_reg     <= '0;
                        sumsq_reg   <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_max_value   = m_max_reg;
    assign m_min_value   = m_min_reg;
    assign m_mean_value  = m_mean_reg;
    assign m_mean_square = m_msq_reg;
    assign m_variance    = m_var_reg;

    `BMMV_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_BATCH), "batch count past limit")
    `BMMV_NEVER(a_div_overlap, div_req.start && div_rsp.busy, "divider restarted while busy")
    `BMMV_ASSERT(a_min_le_max, (count_reg != '0) |-> (min_reg <= max_reg), "min above max")
    `BMMV_ASSERT(a_var_le_msq, out_load |=> (m_variance <= m_mean_square), "variance too large")

endmodule
